@@ hdl/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared operation codes, status codes and result type for the byte deque
// with cursor.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    localparam int Capacity    = 16;
    localparam int OpcodeWidth = 4;
    localparam int ByteWidth   = 8;
    localparam int HandleWidth = 4;
    localparam int StatusWidth = 3;

    typedef enum logic [OpcodeWidth-1:0] {
        OP_PUSH       = 4'd0,
        OP_POP_FRONT  = 4'd1,
        OP_POP_BACK   = 4'd2,
        OP_PEEK_FRONT = 4'd3,
        OP_PEEK_BACK  = 4'd4,
        OP_STEP       = 4'd5,
        OP_CURRENT    = 4'd6,
        OP_RESET      = 4'd7,
        OP_DELETE     = 4'd8
    } opcode_t;

    typedef enum logic [StatusWidth-1:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_FULL       = 3'd2,
        ST_AT_END     = 3'd3,
        ST_BAD_HANDLE = 3'd4
    } status_t;

    typedef struct packed {
        logic [ByteWidth-1:0]   out_byte;
        logic [HandleWidth-1:0] out_handle;
        status_t                status;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/bdq_free_enc.sv @@
// ----------------------------------------------------------------------------
// bdq_free_enc
// Priority encoder that finds the lowest slot of the pool not in use.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_free_enc (
    input  wire logic [bdq_pkg::Capacity-1:0]          in_use,
    output logic                                       found,
    output logic [$clog2(bdq_pkg::Capacity)-1:0]       free_idx
);

    localparam int IdxWidth = $clog2(bdq_pkg::Capacity);

    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = bdq_pkg::Capacity - 1; i >= 0; i--) begin
            if (!in_use[i]) begin
                found    = 1'b1;
                free_idx = IdxWidth'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/bdq_core.sv @@
// ----------------------------------------------------------------------------
// bdq_core
// Node pool, list pointers and cursor. Executes one operation per enabled
// cycle and produces its result combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            exec_en,
    input  wire logic [bdq_pkg::OpcodeWidth-1:0] opcode,
    input  wire logic [bdq_pkg::ByteWidth-1:0]   push_byte,
    input  wire logic                            toward_back,
    input  wire logic [bdq_pkg::HandleWidth-1:0] slot_handle,
    output bdq_pkg::result_t                     result
);

    localparam int IdxWidth = $clog2(bdq_pkg::Capacity);
    localparam int CntWidth = $clog2(bdq_pkg::Capacity + 1);

    logic [bdq_pkg::ByteWidth-1:0] slot_bytes_reg [bdq_pkg::Capacity];
    logic [IdxWidth-1:0]           next_link_reg  [bdq_pkg::Capacity];
    logic [IdxWidth-1:0]           prev_link_reg  [bdq_pkg::Capacity];
    logic [bdq_pkg::Capacity-1:0]  slot_in_use_reg;
    logic [IdxWidth-1:0]           head_slot_reg;
    logic [IdxWidth-1:0]           tail_slot_reg;
    logic [IdxWidth-1:0]           cursor_slot_reg;
    logic [CntWidth-1:0]           item_count_reg;

    logic [IdxWidth-1:0]           next_link_next [bdq_pkg::Capacity];
    logic [IdxWidth-1:0]           prev_link_next [bdq_pkg::Capacity];
    logic [bdq_pkg::Capacity-1:0]  slot_in_use_next;
    logic [IdxWidth-1:0]           head_slot_next;
    logic [IdxWidth-1:0]           tail_slot_next;
    logic [IdxWidth-1:0]           cursor_slot_next;
    logic [CntWidth-1:0]           item_count_next;
    logic                          byte_we;

    logic                          free_found;
    logic [IdxWidth-1:0]           free_idx;

    bdq_free_enc u_free_enc (
        .in_use   (slot_in_use_reg),
        .found    (free_found),
        .free_idx (free_idx)
    );

    always_comb begin
        logic [IdxWidth-1:0] s;
        logic [IdxWidth-1:0] p;
        logic [IdxWidth-1:0] n;
        logic                do_unlink;
        logic                handle_ok;

        next_link_next   = next_link_reg;
        prev_link_next   = prev_link_reg;
        slot_in_use_next = slot_in_use_reg;
        head_slot_next   = head_slot_reg;
        tail_slot_next   = tail_slot_reg;
        cursor_slot_next = cursor_slot_reg;
        item_count_next  = item_count_reg;
        byte_we          = 1'b0;
        do_unlink        = 1'b0;
        s                = IdxWidth'(slot_handle);
        handle_ok        = (32'(slot_handle) < bdq_pkg::Capacity) && slot_in_use_reg[s];
        result.out_byte   = '0;
        result.out_handle = '0;
        result.status     = bdq_pkg::ST_OK;

        if (opcode == bdq_pkg::OP_PUSH) begin
            if (!free_found) begin
                result.status = bdq_pkg::ST_FULL;
            end else begin
                byte_we                    = 1'b1;
                slot_in_use_next[free_idx] = 1'b1;
                next_link_next[free_idx]   = '0;
                item_count_next            = item_count_reg + CntWidth'(1);
                if (item_count_reg == '0) begin
                    prev_link_next[free_idx] = '0;
                    head_slot_next           = free_idx;
                    tail_slot_next           = free_idx;
                    cursor_slot_next         = free_idx;
                end else begin
                    next_link_next[tail_slot_reg] = free_idx;
                    prev_link_next[free_idx]      = tail_slot_reg;
                    tail_slot_next                = free_idx;
                end
            end
        end else if (opcode > bdq_pkg::OP_DELETE) begin
            result.status = bdq_pkg::ST_OK;
        end else if (item_count_reg == '0) begin
            result.status = bdq_pkg::ST_EMPTY;
        end else begin
            unique case (opcode)
                bdq_pkg::OP_POP_FRONT: begin
                    s = head_slot_reg;
                    if (cursor_slot_reg == s) begin
                        cursor_slot_next = next_link_reg[s];
                    end
                    result.out_byte = slot_bytes_reg[s];
                    do_unlink       = 1'b1;
                end
                bdq_pkg::OP_POP_BACK: begin
                    s = tail_slot_reg;
                    if (cursor_slot_reg == s) begin
                        cursor_slot_next = prev_link_reg[s];
                    end
                    result.out_byte = slot_bytes_reg[s];
                    do_unlink       = 1'b1;
                end
                bdq_pkg::OP_PEEK_FRONT: begin
                    result.out_byte = slot_bytes_reg[head_slot_reg];
                end
                bdq_pkg::OP_PEEK_BACK: begin
                    result.out_byte = slot_bytes_reg[tail_slot_reg];
                end
                bdq_pkg::OP_STEP: begin
                    if (toward_back ? (cursor_slot_reg == tail_slot_reg)
                                    : (cursor_slot_reg == head_slot_reg)) begin
                        result.status = bdq_pkg::ST_AT_END;
                    end else begin
                        cursor_slot_next  = toward_back ? next_link_reg[cursor_slot_reg]
                                                        : prev_link_reg[cursor_slot_reg];
                        result.out_byte   = slot_bytes_reg[cursor_slot_next];
                        result.out_handle = bdq_pkg::HandleWidth'(cursor_slot_next);
                    end
                end
                bdq_pkg::OP_CURRENT: begin
                    result.out_byte   = slot_bytes_reg[cursor_slot_reg];
                    result.out_handle = bdq_pkg::HandleWidth'(cursor_slot_reg);
                end
                bdq_pkg::OP_RESET: begin
                    cursor_slot_next = toward_back ? tail_slot_reg : head_slot_reg;
                end
                default: begin
                    if (!handle_ok) begin
                        result.status = bdq_pkg::ST_BAD_HANDLE;
                    end else begin
                        if (cursor_slot_reg == s) begin
                            if (s != head_slot_reg) begin
                                cursor_slot_next = prev_link_reg[s];
                            end else if (s != tail_slot_reg) begin
                                cursor_slot_next = next_link_reg[s];
                            end
                        end
                        do_unlink = 1'b1;
                    end
                end
            endcase
        end

        if (do_unlink) begin
            p                   = prev_link_reg[s];
            n                   = next_link_reg[s];
            slot_in_use_next[s] = 1'b0;
            item_count_next     = item_count_reg - CntWidth'(1);
            if (item_count_reg == CntWidth'(1)) begin
                head_slot_next   = '0;
                tail_slot_next   = '0;
                cursor_slot_next = '0;
            end else begin
                if (s == head_slot_reg) begin
                    head_slot_next = n;
                end else begin
                    next_link_next[p] = n;
                end
                if (s == tail_slot_reg) begin
                    tail_slot_next = p;
                end else begin
                    prev_link_next[n] = p;
                end
            end
        end else begin
            p = '0;
            n = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_in_use_reg <= '0;
            head_slot_reg   <= '0;
            tail_slot_reg   <= '0;
            cursor_slot_reg <= '0;
            item_count_reg  <= '0;
        end else if (exec_en) begin
            slot_in_use_reg <= slot_in_use_next;
            head_slot_reg   <= head_slot_next;
            tail_slot_reg   <= tail_slot_next;
            cursor_slot_reg <= cursor_slot_next;
            item_count_reg  <= item_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_en) begin
            next_link_reg <= next_link_next;
            prev_link_reg <= prev_link_next;
            if (byte_we) begin
                slot_bytes_reg[free_idx] <= push_byte;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/byte_deque_with_cursor_unit.sv @@
// ----------------------------------------------------------------------------
// byte_deque_with_cursor_unit
// Bounded byte deque kept as a doubly linked list in a slot pool, with a
// cursor, one result word per operation word.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                                    Role
//  s_       s_valid s_ready s_opcode s_push_byte s_toward_back       operation in
//           s_slot_handle
//  m_       m_valid m_ready m_out_byte m_out_handle m_status         result out
//
//  An operation word is captured in an input register and executed when the
//  output register is empty or being read, and its result is then written to
//  the output register. One word completes per cycle while the output is not
//  stalled. The whole operation, including the free slot search, is one
//  combinational pass over the pool registers. Reset clears the pool
//  occupancy and the head, tail and cursor pointers at once. A stalled result
//  holds the executing word in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_deque_with_cursor_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [bdq_pkg::OpcodeWidth-1:0] s_opcode,
    input  wire logic [bdq_pkg::ByteWidth-1:0]   s_push_byte,
    input  wire logic                            s_toward_back,
    input  wire logic [bdq_pkg::HandleWidth-1:0] s_slot_handle,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [bdq_pkg::ByteWidth-1:0]        m_out_byte,
    output logic [bdq_pkg::HandleWidth-1:0]      m_out_handle,
    output logic [bdq_pkg::StatusWidth-1:0]      m_status
);

    logic                            in_valid_reg;
    logic [bdq_pkg::OpcodeWidth-1:0] opcode_reg;
    logic [bdq_pkg::ByteWidth-1:0]   push_byte_reg;
    logic                            toward_back_reg;
    logic [bdq_pkg::HandleWidth-1:0] slot_handle_reg;
    logic                            out_valid_reg;
    bdq_pkg::result_t                result_reg;
    bdq_pkg::result_t                result_next;
    logic                            exec_en;

    assign exec_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || exec_en;

    bdq_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .exec_en     (exec_en),
        .opcode      (opcode_reg),
        .push_byte   (push_byte_reg),
        .toward_back (toward_back_reg),
        .slot_handle (slot_handle_reg),
        .result      (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (exec_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            opcode_reg      <= s_opcode;
            push_byte_reg   <= s_push_byte;
            toward_back_reg <= s_toward_back;
            slot_handle_reg <= s_slot_handle;
        end
        if (exec_en) begin
            result_reg <= result_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_byte   = result_reg.out_byte;
    assign m_out_handle = result_reg.out_handle;
    assign m_status     = result_reg.status;

endmodule

`default_nettype wire
